>>> hw/rtl/tocc_pkg.sv
// package for the third-order cross-correlation kernel engine
// types, widths and codes shared by front, back, divider and top level
// no dependencies
package tocc_pkg;

    localparam int DEPTH    = 4096;
    localparam int ADDR_W   = 12;
    localparam int CNT_W    = 13;
    localparam int MAX_LAG  = 16;
    localparam int ML_W     = 5;
    localparam int LAG_W    = 4;
    localparam int STIM_W   = 12;
    localparam int RESP_W   = 16;
    localparam int VAR_W    = 24;
    localparam int ACC_W    = 64;
    localparam int MAG_W    = 61;
    localparam int FRAC_W   = 16;
    localparam int NUM_W    = MAG_W + FRAC_W;
    localparam int DEN_W    = 62;
    localparam int VAL_W    = 48;
    localparam int DIVC_W   = 7;

    localparam logic [ML_W-1:0] MAX_LAG_V = ML_W'(MAX_LAG);

    typedef enum logic [1:0] {
        KIND_APPEND  = 2'd0,
        KIND_QUERY   = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LAG  = 2'd1,
        ST_FEW  = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_MAX_LAG  = 2'd0,
        CFG_VARIANCE = 2'd1,
        CFG_SPARE2   = 2'd2,
        CFG_SPARE3   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_DEN,
        S_MUL,
        S_START,
        S_DIV,
        S_RES
    } t_state;

    typedef struct packed {
        t_kind                     kind;
        logic signed [STIM_W-1:0]  stim_a;
        logic signed [STIM_W-1:0]  stim_b;
        logic signed [STIM_W-1:0]  stim_c;
        logic signed [RESP_W-1:0]  response;
        logic [LAG_W-1:0]          lag_a;
        logic [LAG_W-1:0]          lag_b;
        logic [LAG_W-1:0]          lag_c;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        t_status                 status;
    } t_res;

endpackage

>>> hw/rtl/third_order_cross_correlation_kernel_top.sv
// top level of the third-order cross-correlation kernel engine
// depends on tocc_pkg, tocc_front, tocc_back (which holds tocc_div)
//
// channel   direction  handshake                  payload
// input     in         i_push / o_full            i_kind, stims, i_response, lags
// result    out        o_empty / i_pop            o_kernel_value, o_status
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// append and restart are handled in S_IDLE in the back end; a query with an error
// status goes from S_IDLE straight to S_RES
// a good query walks samples max_lag-1 .. count-1 at one per cycle through the
// single multiply-accumulate chain, then goes through pipeline drain,
// denominator products and the bit-serial divider
// reset is synchronous active low; memories are not cleared, no clearing pass
// a two-entry command queue and a one-entry result register let input and
// output stall independently
module third_order_cross_correlation_kernel_top
    import tocc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [1:0]               i_kind,
    input  logic signed [STIM_W-1:0] i_stim_a,
    input  logic signed [STIM_W-1:0] i_stim_b,
    input  logic signed [STIM_W-1:0] i_stim_c,
    input  logic signed [RESP_W-1:0] i_response,
    input  logic [LAG_W-1:0]         i_lag_a,
    input  logic [LAG_W-1:0]         i_lag_b,
    input  logic [LAG_W-1:0]         i_lag_c,
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic signed [VAL_W-1:0]  o_kernel_value,
    output logic [1:0]               o_status,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [VAR_W-1:0]         i_cfg_data
);

    t_cmd              w_in_cmd;
    t_cmd              w_cmd;
    logic              w_cmd_valid, w_cmd_pop;
    logic              w_res_valid, w_res_ready;
    t_res              w_res;
    logic [ML_W-1:0]   r_max_lag;
    logic [VAR_W-1:0]  r_variance;
    logic              r_out_valid;
    t_res              r_out;

    // pack the input transaction
    assign w_in_cmd.kind     = t_kind'(i_kind);
    assign w_in_cmd.stim_a   = i_stim_a;
    assign w_in_cmd.stim_b   = i_stim_b;
    assign w_in_cmd.stim_c   = i_stim_c;
    assign w_in_cmd.response = i_response;
    assign w_in_cmd.lag_a    = i_lag_a;
    assign w_in_cmd.lag_b    = i_lag_b;
    assign w_in_cmd.lag_c    = i_lag_c;

    tocc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_cmd       (w_in_cmd),
        .o_full      (o_full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    tocc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_max_lag   (r_max_lag),
        .i_variance  (r_variance),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // config registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lag  <= ML_W'(8);
            r_variance <= VAR_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_LAG:  r_max_lag  <= i_cfg_data[ML_W-1:0];
                CFG_VARIANCE: r_variance <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // result register: refills in the cycle the old result is popped
    assign w_res_ready    = !r_out_valid || i_pop;
    assign o_empty        = !r_out_valid;
    assign o_kernel_value = r_out.value;
    assign o_status       = r_out.status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

endmodule

>>> hw/rtl/tocc_front.sv
// front end: takes input transactions, drops unused kinds, queues commands
// depends on tocc_pkg
module tocc_front
    import tocc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    output logic  o_cmd_valid,
    output t_cmd  o_cmd,
    input  logic  i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_wr, w_rd;

    // kind 3 is accepted but never queued
    assign w_wr = i_push && !o_full && (i_cmd.kind != KIND_UNUSED);
    assign w_rd = i_cmd_pop && o_cmd_valid;
    assign o_full = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

>>> hw/rtl/tocc_div.sv
// restoring divider, one quotient bit per cycle
// depends on tocc_pkg
module tocc_div
    import tocc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [DIVC_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});
    assign w_diff  = w_trial - {1'b0, i_den};
    assign o_done  = r_done;
    assign o_quo   = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIVC_W'(1);
                if (r_cnt == DIVC_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

endmodule

>>> hw/rtl/tocc_back.sv
// back end: sample memories, multiply-accumulate walk, normalization
// depends on tocc_pkg and tocc_div
module tocc_back
    import tocc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic [ML_W-1:0]   i_max_lag,
    input  logic [VAR_W-1:0]  i_variance,
    output logic              o_res_valid,
    output t_res              o_res,
    input  logic              i_res_ready
);

    logic signed [STIM_W-1:0] mem_a [DEPTH];
    logic signed [STIM_W-1:0] mem_b [DEPTH];
    logic signed [STIM_W-1:0] mem_c [DEPTH];
    logic signed [RESP_W-1:0] mem_r [DEPTH];

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_t;
    logic [LAG_W-1:0]  r_la, r_lb, r_lc;
    logic              r_v1, r_v2, r_v3;
    logic signed [STIM_W-1:0] r_rd_a, r_rd_b, r_rd_c;
    logic signed [RESP_W-1:0] r_rd_r;
    logic signed [RESP_W+STIM_W-1:0]   r_p1;
    logic signed [2*STIM_W-1:0]        r_p2;
    logic signed [RESP_W+3*STIM_W-1:0] r_p;
    logic signed [ACC_W-1:0] r_acc;
    logic [2*VAR_W-1:0]  r_var2;
    logic [CNT_W-1:0]    r_n;
    logic                r_neg;
    logic [ACC_W-1:0]    r_mag;
    logic [DEN_W-1:0]    r_den;
    logic signed [VAL_W-1:0] r_value;
    t_status             r_status;

    logic [ML_W-1:0]   w_ml;
    logic [CNT_W-1:0]  w_ml_c;
    logic              w_lag_err, w_few;
    logic              w_issue, w_div_start;
    logic [VAR_W-1:0]  w_var;
    logic [NUM_W-1:0]  w_quo;
    logic              w_div_done;
    logic [VAL_W-1:0]  w_limit;
    logic              w_sat;
    logic [VAL_W-1:0]  w_qv;
    logic              w_append;
    logic [ADDR_W-1:0] w_wa;

    assign w_ml      = (i_max_lag > MAX_LAG_V) ? MAX_LAG_V : i_max_lag;
    assign w_ml_c    = {{(CNT_W-ML_W){1'b0}}, w_ml};
    assign w_lag_err = ({1'b0, i_cmd.lag_a} >= w_ml) || ({1'b0, i_cmd.lag_b} >= w_ml)
                    || ({1'b0, i_cmd.lag_c} >= w_ml);
    assign w_few     = (r_count < w_ml_c);
    assign w_var     = (i_variance == '0) ? VAR_W'(1) : i_variance;
    assign w_append  = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.kind == KIND_APPEND)
                    && (r_count < CNT_W'(DEPTH));
    assign w_wa      = r_count[ADDR_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == KIND_QUERY) begin
                    n_state = (w_lag_err || w_few) ? S_RES : S_MAC;
                end
            end
            S_MAC: begin
                if (r_t == r_count - CNT_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = S_DEN;
                end
            end
            S_DEN:   n_state = S_MUL;
            S_MUL:   n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop   = 1'b0;
        w_issue     = 1'b0;
        w_div_start = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            S_IDLE:  o_cmd_pop   = i_cmd_valid;
            S_MAC:   w_issue     = 1'b1;
            S_START: w_div_start = 1'b1;
            S_RES:   o_res_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_res.value  = r_value;
    assign o_res.status = r_status;

    tocc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_mag[MAG_W-1:0], {FRAC_W{1'b0}}}),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign w_limit = r_neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    assign w_sat   = (w_quo[NUM_W-1:VAL_W] != '0) || (w_quo[VAL_W-1:0] > w_limit);
    assign w_qv    = w_sat ? w_limit : w_quo[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            if (w_append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (r_state == S_IDLE && i_cmd_valid && i_cmd.kind == KIND_RESTART) begin
                r_count <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid && i_cmd.kind == KIND_QUERY) begin
            r_la     <= i_cmd.lag_a;
            r_lb     <= i_cmd.lag_b;
            r_lc     <= i_cmd.lag_c;
            r_t      <= w_ml_c - CNT_W'(1);
            r_acc    <= '0;
            r_value  <= '0;
            r_status <= w_lag_err ? ST_LAG : ST_FEW;
        end
        if (r_state == S_MAC) begin
            r_t <= r_t + CNT_W'(1);
        end
        r_p1 <= r_rd_r * r_rd_a;
        r_p2 <= r_rd_b * r_rd_c;
        r_p  <= r_p1 * r_p2;
        if (r_v3) begin
            r_acc <= r_acc + ACC_W'(r_p);
        end
        if (r_state == S_DEN) begin
            r_var2 <= w_var * w_var;
            r_n    <= r_count - w_ml_c + CNT_W'(1);
            r_neg  <= r_acc[ACC_W-1];
            r_mag  <= r_acc[ACC_W-1] ? (ACC_W'(0) - r_acc) : r_acc;
        end
        if (r_state == S_MUL) begin
            r_den <= {{(DEN_W-2*VAR_W-1){1'b0}}, r_var2, 1'b0}
                   * {{(DEN_W-CNT_W){1'b0}}, r_n};
        end
        if (r_state == S_DIV && w_div_done) begin
            r_value  <= r_neg ? (VAL_W'(0) - w_qv) : w_qv;
            r_status <= w_sat ? ST_SAT : ST_OK;
        end
    end

    // sample memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_append) begin
            mem_a[w_wa] <= i_cmd.stim_a;
        end
        r_rd_a <= mem_a[r_t[ADDR_W-1:0] - {{(ADDR_W-LAG_W){1'b0}}, r_la}];
    end

    always_ff @(posedge i_clk) begin
        if (w_append) begin
            mem_b[w_wa] <= i_cmd.stim_b;
        end
        r_rd_b <= mem_b[r_t[ADDR_W-1:0] - {{(ADDR_W-LAG_W){1'b0}}, r_lb}];
    end

    always_ff @(posedge i_clk) begin
        if (w_append) begin
            mem_c[w_wa] <= i_cmd.stim_c;
        end
        r_rd_c <= mem_c[r_t[ADDR_W-1:0] - {{(ADDR_W-LAG_W){1'b0}}, r_lc}];
    end

    always_ff @(posedge i_clk) begin
        if (w_append) begin
            mem_r[w_wa] <= i_cmd.response;
        end
        r_rd_r <= mem_r[r_t[ADDR_W-1:0]];
    end

endmodule
